// ===== hw/rtl/md5_message_digest_macros.svh =====
// Assertion macros for the MD5 block
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH
`ifndef ASSERT_OFF
`define MD5_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define MD5_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m: label");
`else
`define MD5_ASSERT(label, clk, rst, prop)
`define MD5_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== hw/rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Constants, types and round tables shared by the MD5 front and back ends.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned FifoDepth  = 4;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // one request from the front end to the back end
  typedef struct packed {
    logic [31:0] data;    // word to store
    logic [3:0]  slot;    // buffer slot
    logic        compress; // run the rounds after this write
    logic        finish;   // emit the digest after the rounds
  } md5_cmd_t;

  function automatic logic [31:0] sine_add(input logic [5:0] r);
    logic [31:0] t [64];
    t = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[r];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] t [16];
    t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return t[{r[5:4], r[1:0]}];
  endfunction

  // message word used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] i;
    i = r[3:0];
    case (r[5:4])
      2'd0:    return i;
      2'd1:    return 4'(5 * i + 1);
      2'd2:    return 4'(3 * i + 5);
      default: return 4'(7 * i);
    endcase
  endfunction

endpackage

// ===== hw/rtl/md5_front.sv =====
// ----------------------------------------------------------------------------
// md5_front
// Takes message words, tracks position and bit length, and turns each word
// into buffer writes, including pad and length words on the final word.
// ----------------------------------------------------------------------------
module md5_front import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  input  logic        push,
  output logic        full,
  output md5_cmd_t    cmd,
  output logic        cmd_valid,
  input  logic        cmd_ready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PAD  = 3'b010,
    ST_TAIL = 3'b100
  } fst_t;

  fst_t        state, state_next;
  logic [3:0]  pos;
  logic [63:0] bit_length;
  logic        pad_pending; // 0x80 still owed in next word

  logic [2:0]  cnt;
  logic [31:0] keep, padded;
  logic        accept;

  assign cnt    = (byte_count > 3'd4) ? 3'd4 : byte_count;
  assign keep   = (cnt == 3'd0) ? 32'h0 :
                  (cnt == 3'd1) ? 32'h0000_00ff :
                  (cnt == 3'd2) ? 32'h0000_ffff :
                  (cnt == 3'd3) ? 32'h00ff_ffff : 32'hffff_ffff;
  assign padded = (data_word & keep) |
                  ((cnt == 3'd4) ? 32'h0 : (32'h80 << {cnt[1:0], 3'b000}));
  assign full   = (state != ST_IDLE) || !cmd_ready;
  assign accept = push && !full;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd_valid  = 1'b0;
    cmd.slot   = pos;
    unique case (state)
      ST_IDLE: begin
        cmd_valid = accept;
        if (!last) begin
          cmd.data     = data_word;
          cmd.compress = (pos == 4'd15);
        end else begin
          cmd.data     = padded;
          cmd.compress = (pos == 4'd15);
          state_next   = (cnt == 3'd4 || pos >= 4'd14) ? ST_PAD : ST_TAIL;
          if (cnt != 3'd4 && pos == 4'd13) state_next = ST_TAIL;
        end
      end
      ST_PAD: begin
        cmd_valid    = cmd_ready;
        cmd.data     = pad_pending ? 32'h80 : 32'h0;
        cmd.compress = (pos == 4'd15);
        // after a pad word, go to tail only if the length fits
        if (cmd_ready && pos <= 4'd13)
          state_next = ST_TAIL;
      end
      default: begin
        cmd_valid    = cmd_ready;
        cmd.data     = (pos == 4'd14) ? bit_length[31:0] :
                       (pos == 4'd15) ? bit_length[63:32] : 32'h0;
        cmd.compress = (pos == 4'd15);
        cmd.finish   = (pos == 4'd15);
        if (cmd_ready && pos == 4'd15) state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos         <= '0;
      bit_length  <= '0;
      pad_pending <= 1'b0;
    end else begin
      if (cmd_valid) begin
        state <= state_next;
        // wraps to slot 0 after slot 15, also after the length word
        pos   <= pos + 4'd1;
        if (state == ST_IDLE) begin
          bit_length  <= bit_length + (last ? 64'({cnt, 3'b000}) : 64'd32);
          pad_pending <= last && (cnt == 3'd4);
        end else begin
          pad_pending <= 1'b0;
        end
        if (state == ST_TAIL && pos == 4'd15) begin
          bit_length <= '0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/md5_back.sv =====
// ----------------------------------------------------------------------------
// md5_back
// Block buffer, 64-round compression at one round per cycle, chaining
// registers and a digest word select on the chaining registers.
// ----------------------------------------------------------------------------
`include "md5_message_digest_macros.svh"
module md5_back import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md5_cmd_t    cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word,
  output logic        empty,
  input  logic        pop
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_OUT   = 4'b1000
  } bst_t;

  bst_t        state;
  logic [31:0] block_buffer [BlockWords];
  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic [5:0]  round_count;
  logic        finish;
  logic [1:0]  out_idx;
  logic [31:0] fv, sum, rot, mword;
  logic [4:0]  sh;

  assign mword = block_buffer[msg_index(round_count)];
  assign sh    = rot_amt(round_count);
  always_comb begin
    case (round_count[5:4])
      2'd0:    fv = (wb & wc) | (~wb & wd);
      2'd1:    fv = (wb & wd) | (wc & ~wd);
      2'd2:    fv = wb ^ wc ^ wd;
      default: fv = wc ^ (wb | ~wd);
    endcase
  end
  assign sum   = wa + fv + mword + sine_add(round_count);
  assign rot   = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  assign cmd_pop = (state == ST_LOAD) && cmd_valid;

  assign empty       = (state != ST_OUT);
  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 2'd3);

  always_ff @(posedge clk) begin
    if (cmd_pop) block_buffer[cmd.slot] <= cmd.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      round_count <= '0;
      finish      <= 1'b0;
      out_idx     <= '0;
      chain       <= '{InitA, InitB, InitC, InitD};
      {wa, wb, wc, wd} <= '0;
    end else begin
      unique case (state)
        ST_LOAD: if (cmd_pop && cmd.compress) begin
          state       <= ST_ROUND;
          finish      <= cmd.finish;
          round_count <= '0;
          {wa, wb, wc, wd} <= {chain[0], chain[1], chain[2], chain[3]};
        end
        ST_ROUND: begin
          wa <= wd;
          wb <= wb + rot;
          wc <= wb;
          wd <= wc;
          round_count <= round_count + 6'd1;
          if (round_count == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          chain[0] <= chain[0] + wa;
          chain[1] <= chain[1] + wb;
          chain[2] <= chain[2] + wc;
          chain[3] <= chain[3] + wd;
          out_idx  <= '0;
          state    <= finish ? ST_OUT : ST_LOAD;
        end
        default: if (pop) begin
          out_idx <= out_idx + 2'd1;
          if (out_idx == 2'd3) begin
            chain <= '{InitA, InitB, InitC, InitD};
            state <= ST_LOAD;
          end
        end
      endcase
    end
  end

  `MD5_ASSERT(a_no_pop_in_rounds, clk, rst, (state == ST_ROUND) |-> !cmd_pop)
  `MD5_ASSERT(a_round_end, clk, rst, (state == ST_ROUND && round_count == 6'd63) |=> (state == ST_ADD))
  `MD5_ASSERT(a_chain_reset, clk, rst, (!empty && pop && last_word) |=> (chain[0] == InitA))

endmodule

// ===== hw/rtl/md5_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// md5_cmd_fifo
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module md5_cmd_fifo import md5_pkg::*; #(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  md5_cmd_t wr_cmd,
  input  logic     wr_en,
  output logic     wr_ready,
  output md5_cmd_t rd_cmd,
  output logic     rd_valid,
  input  logic     rd_en
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  md5_cmd_t       mem [Depth];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    cnt;

  assign wr_ready = (cnt != (AW+1)'(Depth));
  assign rd_valid = (cnt != '0);
  assign rd_cmd   = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en && wr_ready) mem[wp] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr_en && wr_ready) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + AW'(1);
      if (rd_en && rd_valid) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + AW'(1);
      cnt <= cnt + (AW+1)'(wr_en && wr_ready) - (AW+1)'(rd_en && rd_valid);
    end
  end

endmodule

// ===== hw/rtl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// Streaming MD5 hash: message words in, four digest words out per message.
// ----------------------------------------------------------------------------
// Input queue: push/full with data_word, byte_count, last. Words go in
// first byte in bits 7..0; byte_count matters on the last word only.
// Output queue: empty/pop; four requests A..D, last_word on D.
// The front end turns each word into buffer writes (plus pad and length
// words after the last one) and queues them; the back end stores them and
// runs one MD5 round per cycle, 64 rounds and then an add step per block.
// Loading the 16 words, the rounds and the add do not overlap: the back
// end takes no new word while rounds run. After the last word the front
// end writes up to 18 pad and length words. While the digest waits
// unpopped the back end holds and the queue fills, so full rises. Reset
// returns the chain to the initial values and clears the length and
// position; no clearing pass is needed.
// ----------------------------------------------------------------------------
module md5_message_digest import md5_pkg::*; #(
  parameter int unsigned QueueDepth = FifoDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  input  logic        push,
  output logic        full,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word,
  output logic        empty,
  input  logic        pop
);

  md5_cmd_t f_cmd, b_cmd;
  logic     f_valid, f_ready, b_valid, b_pop;

  md5_front u_front (
    .clk, .rst, .data_word, .byte_count, .last, .push, .full,
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  md5_cmd_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk, .rst, .wr_cmd(f_cmd), .wr_en(f_valid), .wr_ready(f_ready),
    .rd_cmd(b_cmd), .rd_valid(b_valid), .rd_en(b_pop)
  );

  md5_back u_back (
    .clk, .rst, .cmd(b_cmd), .cmd_valid(b_valid), .cmd_pop(b_pop),
    .digest_word, .word_index, .last_word, .empty, .pop
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// MD5 streaming digest testbench
// Drives messages as little-endian words with a byte count and last flag on
// the final word, predicts the four digest words per message with an
// independent MD5 model and compares every popped request field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import md5_pkg::*;

  typedef struct packed {
    logic [31:0] digest;
    logic [1:0]  idx;
    logic        fin;
  } digest_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  logic        empty;
  logic        pop = 1'b0;

  md5_message_digest DUT (
    .clk(clk), .rst(rst), .data_word(data_word), .byte_count(byte_count),
    .last(last), .push(push), .full(full), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word), .empty(empty), .pop(pop)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] hash_chain [4];
  logic [31:0] msg_block [16];
  logic [3:0]  msg_pos;
  logic [63:0] msg_bits;
  digest_req_t digest_q[$];

  int  errors = 0;
  int  messages = 0;
  int  words_sent = 0;
  int  digests_seen = 0;
  longint cycles = 0;
  int  burst_left = 0;
  bit  stall_enable = 1'b1;

  localparam longint CycleLimit = 2000000;

  function automatic logic [31:0] md5_const(input int r);
    return 32'(longint'($floor(((r + 1.0) < 0 ? 0 : 4294967296.0 *
      ($sin(r + 1.0) < 0 ? -$sin(r + 1.0) : $sin(r + 1.0))))));
  endfunction

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, s;
    int          g, sh;
    int          shifts [16];
    shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin f = (b & c) | (~b & d); g = r; end
        1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
        2: begin f = b ^ c ^ d;          g = (3 * r + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
      endcase
      s = a + f + msg_block[g] + md5_const(r);
      sh = shifts[(r / 16) * 4 + r % 4];
      a = d; d = c; c = b;
      b = b + ((s << sh) | (s >> (32 - sh)));
    end
    hash_chain[0] += a; hash_chain[1] += b;
    hash_chain[2] += c; hash_chain[3] += d;
  endtask

  task automatic md5_restart();
    hash_chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    msg_pos = '0;
    msg_bits = '0;
  endtask

  task automatic md5_absorb(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
    int n;
    n = (cnt > 4) ? 4 : int'(cnt);
    if (!fin) begin
      msg_block[msg_pos] = w;
      msg_bits += 32;
      msg_pos++;
      if (msg_pos == 0) md5_compress();
      return;
    end
    msg_bits += 64'(8 * n);
    if (n < 4) begin
      msg_block[msg_pos] = (w & ((32'd1 << (8 * n)) - 1)) | (32'h80 << (8 * n));
      msg_pos++;
    end else begin
      msg_block[msg_pos] = w;
      msg_pos++;
      if (msg_pos == 0) md5_compress();
      msg_block[msg_pos] = 32'h80;
      msg_pos++;
    end
    // pad overruns the length slots: needs an extra block
    if (msg_pos == 15 || msg_pos == 0) begin
      while (msg_pos != 0) begin
        msg_block[msg_pos] = '0;
        msg_pos++;
      end
      md5_compress();
    end
    while (msg_pos < 14) begin
      msg_block[msg_pos] = '0;
      msg_pos++;
    end
    msg_block[14] = msg_bits[31:0];
    msg_block[15] = msg_bits[63:32];
    md5_compress();
    for (int k = 0; k < 4; k++) digest_q.push_back('{hash_chain[k], 2'(k), k == 3});
    md5_restart();
    messages++;
  endtask

  // send one word, honouring the burst/gap pattern
  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    data_word <= w; byte_count <= cnt; last <= fin; push <= 1'b1;
    do @(posedge clk); while (full);
    md5_absorb(w, cnt, fin);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender();
    push <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_message(input int nwords, input logic [2:0] tail_cnt);
    for (int i = 0; i < nwords; i++)
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom, tail_cnt, 1'b1);
  endtask

  task automatic drain();
    idle_sender();
    while (digest_q.size() != 0 && cycles < CycleLimit) @(negedge clk);
  endtask

  task automatic test_empty_message();
    send_word(32'hdeadbeef, 3'd0, 1'b1);
    drain();
  endtask

  task automatic test_known_string();
    // "abc"
    send_word(32'h00636261, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h00000000, 3'd4, 1'b1);
    drain();
  endtask

  task automatic test_block_boundaries();
    // tail positions around slots 13..15 and a full block
    send_message(13, 3'd3);
    send_message(13, 3'd4);
    send_message(14, 3'd0);
    send_message(14, 3'd4);
    send_message(15, 3'd2);
    send_message(15, 3'd4);
    send_message(16, 3'd1);
    drain();
  endtask

  task automatic test_odd_counts();
    send_message(2, 3'd5);
    send_message(1, 3'd7);
    send_message(0, 3'd6);
    send_word(32'hffffffff, 3'd1, 1'b0);
    send_word(32'h12345678, 3'd2, 1'b1);
    drain();
  endtask

  task automatic test_random_messages();
    int len;
    while (words_sent < 480) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 18);
      send_message(len, 3'($urandom_range(0, 7)));
      if ($urandom_range(15) == 0) drain();
    end
    stall_enable = 1'b0;
    send_message(20, 3'd4);
    send_message(3, 3'd2);
    drain();
  endtask

  // receiver: its own stall pattern
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else if (!stall_enable) pop <= 1'b1;
    else pop <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(3) != 0);
  end

  always @(posedge clk) begin
    digest_req_t exp_req;
    cycles++;
    if (!rst && pop && !empty) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        $error("digest request with nothing expected: %h", digest_word);
        errors++;
      end else begin
        exp_req = digest_q.pop_front();
        if (digest_word !== exp_req.digest) begin
          $error("digest_word expected %h actual %h", exp_req.digest, digest_word);
          errors++;
        end
        if (word_index !== exp_req.idx) begin
          $error("word_index expected %0d actual %0d", exp_req.idx, word_index);
          errors++;
        end
        if (last_word !== exp_req.fin) begin
          $error("last_word expected %0d actual %0d", exp_req.fin, last_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    md5_restart();
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_message();
    test_known_string();
    test_block_boundaries();
    test_odd_counts();
    test_random_messages();
    repeat (200) @(negedge clk);
    if (digest_q.size() != 0) begin
      $error("%0d digest words never arrived", digest_q.size());
      errors++;
    end
    $display("%0d messages, %0d words pushed, %0d digest words checked",
             messages, words_sent, digests_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== md5_message_digest.f =====
+incdir+hw/rtl
hw/rtl/md5_pkg.sv
hw/rtl/md5_front.sv
hw/rtl/md5_back.sv
hw/rtl/md5_cmd_fifo.sv
hw/rtl/md5_message_digest.sv
tb/tb_top.sv
